@@ hw/rtl/esc_pkg.sv @@
// types, constants and character class functions for the expression syntax checker
`default_nettype none
package esc_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned DepthW = 8;
  localparam int unsigned NameW  = 40;
  localparam int unsigned NCntW  = 3;
  localparam int unsigned DotW   = 2;
  localparam int unsigned CntW   = 8;
  localparam int unsigned MaskW  = 6;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;
  localparam int unsigned NumFn  = 9;

  localparam logic [CntW-1:0]   LimitReset = 8'd255;
  localparam logic [CntW-1:0]   CntMax     = 8'd255;
  localparam logic [DepthW-1:0] DepthMax   = 8'd255;
  localparam logic [NCntW-1:0]  NameStore  = 3'd5;
  localparam logic [NCntW-1:0]  NameMax    = 3'd7;
  localparam logic [DotW-1:0]   DotMax     = 2'd2;

  // fail mask bit positions
  localparam int unsigned FailLen   = 0;
  localparam int unsigned FailAlpha = 1;
  localparam int unsigned FailBrack = 2;
  localparam int unsigned FailSign  = 3;
  localparam int unsigned FailFunc  = 4;
  localparam int unsigned FailNum   = 5;

  // register index of the length limit
  localparam logic RegLimit = 1'b0;

  localparam logic [CharW-1:0] ChOpen  = 8'h28;
  localparam logic [CharW-1:0] ChClose = 8'h29;
  localparam logic [CharW-1:0] ChDot   = 8'h2e;
  localparam logic [CharW-1:0] ChX     = 8'h78;

  // function names, first letter in the low byte
  localparam logic [NumFn-1:0][NameW-1:0] FnNames = {
    40'h0000676f6c,  // log
    40'h0000006e6c,  // ln
    40'h0074727173,  // sqrt
    40'h006e617461,  // atan
    40'h006e697361,  // asin
    40'h00736f6361,  // acos
    40'h00006e6174,  // tan
    40'h00006e6973,  // sin
    40'h0000736f63   // cos
  };

  typedef struct packed {
    logic [CharW-1:0]  prev_char;
    logic [DepthW-1:0] depth;
    logic [NameW-1:0]  letters;
    logic [NCntW-1:0]  name_count;
    logic [DotW-1:0]   dot_count;
    logic [CntW-1:0]   char_count;
    logic [MaskW-1:0]  viol;
  } esc_state_t;

  function automatic logic is_alpha(input logic [CharW-1:0] c);
    logic r;
    case (c) inside
      ".", ["0":"9"], "(", ")", "+", "~", "-", "*", "/", "^", "%",
      "a", "c", "g", "i", "l", "n", "o", "q", "r", "s", "t", "x": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_sign(input logic [CharW-1:0] c);
    logic r;
    case (c) inside
      "+", "-", "*", "/", "^", "%": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(input logic [CharW-1:0] c);
    logic r;
    case (c) inside
      ["0":"9"]: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_letter(input logic [CharW-1:0] c);
    logic r;
    case (c) inside
      "a", "c", "g", "i", "l", "n", "o", "q", "r", "s", "t": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // letters that may open a function name
  function automatic logic is_fn_head(input logic [CharW-1:0] c);
    logic r;
    case (c) inside
      "c", "s", "t", "a", "l": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic fn_match(input logic [NameW-1:0] letters);
    logic r;
    r = 1'b0;
    for (int f = 0; f < NumFn; f++) begin
      if (letters == FnNames[f]) r = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/esc_cfg.sv @@
// configuration register file with the length limit
`default_nettype none
module esc_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [esc_pkg::AddrW-1:0]   paddr,
  input  wire logic [esc_pkg::DataW-1:0]   pwdata,
  output logic      [esc_pkg::DataW-1:0]   prdata,
  output logic                             pready,
  output logic      [esc_pkg::CntW-1:0]    limit_o
);

  logic [esc_pkg::CntW-1:0] limit_q, limit_d;
  logic                     sel_limit;

  assign sel_limit = (paddr[esc_pkg::AddrW-1] == esc_pkg::RegLimit);

  always_comb begin
    limit_d = limit_q;
    if (psel && penable && pwrite && sel_limit) limit_d = pwdata[esc_pkg::CntW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= esc_pkg::LimitReset;
    end else begin
      limit_q <= limit_d;
    end
  end

  assign prdata  = sel_limit ? {{(esc_pkg::DataW-esc_pkg::CntW){1'b0}}, limit_q} : '0;
  assign pready  = 1'b1;
  assign limit_o = limit_q;

endmodule
`default_nettype wire

@@ hw/rtl/esc_rules.sv @@
// per-character syntax rules and next expression state
`default_nettype none
module esc_rules (
  input  wire esc_pkg::esc_state_t          st_i,
  input  wire logic [esc_pkg::CharW-1:0]    ch_i,
  input  wire logic [esc_pkg::CntW-1:0]     limit_i,
  output esc_pkg::esc_state_t               st_o,
  output logic      [esc_pkg::MaskW-1:0]    final_mask_o
);

  logic [esc_pkg::CharW-1:0] p;
  logic                      has_prev;
  logic                      prev_first;
  logic [esc_pkg::MaskW-1:0] hit;
  logic [esc_pkg::MaskW-1:0] mid_mask;
  logic [esc_pkg::DotW-1:0]  dot_inc;

  assign p          = st_i.prev_char;
  assign has_prev   = (st_i.char_count != '0);
  assign prev_first = (st_i.char_count == esc_pkg::CntW'(1));

  always_comb begin
    hit  = '0;
    st_o = st_i;
    dot_inc = st_i.dot_count;

    hit[esc_pkg::FailAlpha] = !esc_pkg::is_alpha(ch_i);

    if (has_prev) begin
      if (ch_i == esc_pkg::ChOpen && (p == esc_pkg::ChDot || p == esc_pkg::ChClose ||
          esc_pkg::is_digit(p) || p == esc_pkg::ChX))
        hit[esc_pkg::FailBrack] = 1'b1;
      if (ch_i == esc_pkg::ChClose && (p == esc_pkg::ChDot || p == esc_pkg::ChOpen ||
          esc_pkg::is_sign(p)))
        hit[esc_pkg::FailBrack] = 1'b1;
      if (!prev_first && p == esc_pkg::ChOpen && (ch_i == esc_pkg::ChDot ||
          ch_i == esc_pkg::ChClose || esc_pkg::is_sign(ch_i)))
        hit[esc_pkg::FailBrack] = 1'b1;
      if (!prev_first && p == esc_pkg::ChClose && (ch_i == esc_pkg::ChDot ||
          ch_i == esc_pkg::ChOpen || esc_pkg::is_digit(ch_i) || ch_i == esc_pkg::ChX ||
          esc_pkg::is_fn_head(ch_i)))
        hit[esc_pkg::FailBrack] = 1'b1;
      if (esc_pkg::is_sign(p) && esc_pkg::is_sign(ch_i))
        hit[esc_pkg::FailSign] = 1'b1;
      if (esc_pkg::is_digit(ch_i) && (p == esc_pkg::ChClose || p == esc_pkg::ChX))
        hit[esc_pkg::FailNum] = 1'b1;
      if (esc_pkg::is_digit(p) && (ch_i == esc_pkg::ChOpen || ch_i == esc_pkg::ChX ||
          esc_pkg::is_fn_head(ch_i)))
        hit[esc_pkg::FailNum] = 1'b1;
      if (ch_i == esc_pkg::ChX && (p == esc_pkg::ChX || p == esc_pkg::ChClose ||
          esc_pkg::is_digit(p)))
        hit[esc_pkg::FailNum] = 1'b1;
      if (p == esc_pkg::ChX && (ch_i == esc_pkg::ChOpen || esc_pkg::is_digit(ch_i) ||
          esc_pkg::is_fn_head(ch_i)))
        hit[esc_pkg::FailNum] = 1'b1;
    end

    // bracket depth
    if (ch_i == esc_pkg::ChOpen) begin
      if (st_i.depth != esc_pkg::DepthMax) st_o.depth = st_i.depth + 1'b1;
    end else if (ch_i == esc_pkg::ChClose) begin
      if (st_i.depth == '0) hit[esc_pkg::FailBrack] = 1'b1;
      else st_o.depth = st_i.depth - 1'b1;
    end

    // function name letters
    if (esc_pkg::is_letter(ch_i)) begin
      if (st_i.name_count < esc_pkg::NameStore)
        st_o.letters = st_i.letters |
                       ({{(esc_pkg::NameW-esc_pkg::CharW){1'b0}}, ch_i} << {st_i.name_count, 3'b000});
      if (st_i.name_count != esc_pkg::NameMax) st_o.name_count = st_i.name_count + 1'b1;
    end else if (st_i.name_count != '0) begin
      if (ch_i != esc_pkg::ChOpen || !esc_pkg::fn_match(st_i.letters))
        hit[esc_pkg::FailFunc] = 1'b1;
      st_o.letters    = '0;
      st_o.name_count = '0;
    end

    // dots in a number
    if (ch_i == esc_pkg::ChDot) begin
      if (st_i.dot_count != esc_pkg::DotMax) dot_inc = st_i.dot_count + 1'b1;
      if (dot_inc > esc_pkg::DotW'(1)) hit[esc_pkg::FailNum] = 1'b1;
      st_o.dot_count = dot_inc;
    end else if (!esc_pkg::is_digit(ch_i)) begin
      st_o.dot_count = '0;
    end

    if (st_i.char_count != esc_pkg::CntMax) st_o.char_count = st_i.char_count + 1'b1;
    st_o.prev_char = ch_i;
    st_o.viol      = st_i.viol | hit;
  end

  assign mid_mask = st_i.viol | hit;

  // end of expression checks
  always_comb begin
    final_mask_o = mid_mask;
    if (st_o.depth != '0)            final_mask_o[esc_pkg::FailBrack] = 1'b1;
    if (st_o.name_count != '0)       final_mask_o[esc_pkg::FailFunc]  = 1'b1;
    if (st_o.char_count >= limit_i)  final_mask_o[esc_pkg::FailLen]   = 1'b1;
  end

endmodule
`default_nettype wire

@@ hw/rtl/expression_syntax_checker.sv @@
// top level of the expression syntax checker
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_stall_o   char_code_i, is_last_i
//   result    out        out_valid_o / out_stall_i is_valid_o, fail_mask_o
//   config    in         apb psel/penable/pready   length_limit at byte 0
//
// one character per cycle while in_stall_o is low; a last character passes the input
// register, then the rule logic into the result register
// reset clears the expression state and sets length_limit to 255
// a last character waits in the input register while the result register is
// full and stalled; other characters keep flowing
`default_nettype none
module expression_syntax_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [esc_pkg::CharW-1:0]   char_code_i,
  input  wire logic                        is_last_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             is_valid_o,
  output logic      [esc_pkg::MaskW-1:0]   fail_mask_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [esc_pkg::AddrW-1:0]   paddr,
  input  wire logic [esc_pkg::DataW-1:0]   pwdata,
  output logic      [esc_pkg::DataW-1:0]   prdata,
  output logic                             pready
);

  logic [esc_pkg::CntW-1:0]  limit;
  logic                      s1_valid_q, s1_valid_d;
  logic [esc_pkg::CharW-1:0] s1_char_q;
  logic                      s1_last_q;
  logic                      proc_go;
  logic                      s1_take;
  esc_pkg::esc_state_t       st_q, st_d, st_next;
  logic [esc_pkg::MaskW-1:0] final_mask;
  logic                      res_valid_q, res_valid_d;
  logic [esc_pkg::MaskW-1:0] res_mask_q;
  logic                      res_ok_q;

  esc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  esc_rules u_rules (
    .st_i         (st_q),
    .ch_i         (s1_char_q),
    .limit_i      (limit),
    .st_o         (st_next),
    .final_mask_o (final_mask)
  );

  assign proc_go    = s1_valid_q && (!s1_last_q || !res_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !proc_go;
  assign s1_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_take)      s1_valid_d = 1'b1;
    else if (proc_go) s1_valid_d = 1'b0;
  end

  always_comb begin
    st_d = st_q;
    if (proc_go) st_d = s1_last_q ? '0 : st_next;
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (proc_go && s1_last_q) res_valid_d = 1'b1;
    else if (!out_stall_i)    res_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      st_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      st_q        <= st_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      s1_char_q <= char_code_i;
      s1_last_q <= is_last_i;
    end
    if (proc_go && s1_last_q) begin
      res_mask_q <= final_mask;
      res_ok_q   <= (final_mask == '0);
    end
  end

  assign out_valid_o = res_valid_q;
  assign is_valid_o  = res_ok_q;
  assign fail_mask_o = res_mask_q;

  // a new result only comes from a last character leaving the input register
  a_res_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(proc_go && s1_last_q))
    else $error("result without a last character");

  // the pass flag agrees with the mask
  a_ok_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_ok_q == (res_mask_q == '0)))
    else $error("is_valid disagrees with fail_mask");

  // expression state is cleared once a result is formed
  a_state_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_go && s1_last_q) |=> (st_q.char_count == '0 && st_q.viol == '0 &&
                                st_q.depth == '0))
    else $error("state not cleared after result");

  // the input register never drops a request while stalled
  a_hold_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> s1_valid_q)
    else $error("stalled request lost");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// self-checking testbench for the expression syntax checker: character stream in, verdicts checked
`timescale 1ns / 100ps
module tb;

  typedef struct packed {
    logic                       ok;
    logic [esc_pkg::MaskW-1:0]  mask;
  } verdict_t;

  localparam logic [esc_pkg::AddrW-1:0] LimitAddr = esc_pkg::AddrW'(4 * esc_pkg::RegLimit);
  localparam int NumRows = 11;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [esc_pkg::CharW-1:0]   char_code_i;
  logic                        is_last_i;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic                        is_valid_o;
  logic [esc_pkg::MaskW-1:0]   fail_mask_o;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [esc_pkg::AddrW-1:0]   paddr;
  logic [esc_pkg::DataW-1:0]   pwdata;
  logic [esc_pkg::DataW-1:0]   prdata;
  logic                        pready;

  // shadow of the checker state
  logic [esc_pkg::CharW-1:0]   prev_ch;
  logic [esc_pkg::DepthW-1:0]  open_count;
  logic [esc_pkg::NameW-1:0]   name_buf;
  logic [esc_pkg::NCntW-1:0]   name_len;
  logic [esc_pkg::DotW-1:0]    dot_run;
  logic [esc_pkg::CntW-1:0]    char_len;
  logic [esc_pkg::MaskW-1:0]   flags;
  logic [esc_pkg::CntW-1:0]    limit;

  verdict_t                    verdict_q[$];
  logic [esc_pkg::CharW-1:0]   formula_q[$];
  bit                          calm = 1'b0;
  int                          sent = 0;
  int                          fails = 0;

  // '#' stands for a nul byte, '$' for 0xff
  string row_text [NumRows] = '{"1", ")", "(-1)", "co", "1..5", "2*-3", "#", "$",
                                "acossss(x)", "2x", "ln(x)^9%2"};
  int    row_mask [NumRows] = '{0, 4, 0, 16, 32, 8, 2, 2, -1, 32, -1};
  int    phase_limit [6]    = '{255, 1, 0, 9, 255, 128};

  expression_syntax_checker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_valid_o  (is_valid_o),
    .fail_mask_o (fail_mask_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit in_set(input string s, input logic [7:0] c);
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic string fn_name(input int k);
    case (k)
      0: return "cos";
      1: return "sin";
      2: return "tan";
      3: return "acos";
      4: return "asin";
      5: return "atan";
      6: return "sqrt";
      7: return "ln";
      default: return "log";
    endcase
  endfunction

  function automatic bit name_known();
    string s;
    logic [esc_pkg::NameW-1:0] packed_name;
    for (int k = 0; k < esc_pkg::NumFn; k++) begin
      s = fn_name(k);
      packed_name = '0;
      for (int i = 0; i < s.len(); i++) packed_name[8*i +: 8] = s[i];
      if (s.len() == name_len && packed_name == name_buf) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void forget_formula();
    prev_ch    = '0;
    open_count = '0;
    name_buf   = '0;
    name_len   = '0;
    dot_run    = '0;
    char_len   = '0;
    flags      = '0;
  endfunction

  // returns 1 when the character closes an expression and fills v
  function automatic bit judge_char(input logic [7:0] c, input bit last, output verdict_t v);
    logic [7:0] p;
    bit has_prev;
    bit prev_first;
    p = prev_ch;
    has_prev = char_len != 0;
    prev_first = char_len == 1;
    v = '0;
    if (!in_set(".0123456789()+~-*/^%acgilnoqrstx", c)) flags[esc_pkg::FailAlpha] = 1'b1;
    if (has_prev) begin
      if (c == "(" && in_set(".)0123456789x", p)) flags[esc_pkg::FailBrack] = 1'b1;
      if (c == ")" && in_set(".(+-*/^%", p)) flags[esc_pkg::FailBrack] = 1'b1;
      if (!prev_first && p == "(" && in_set(".)+-*/^%", c)) flags[esc_pkg::FailBrack] = 1'b1;
      if (!prev_first && p == ")" && in_set(".(0123456789xcstal", c))
        flags[esc_pkg::FailBrack] = 1'b1;
      if (in_set("+-*/^%", p) && in_set("+-*/^%", c)) flags[esc_pkg::FailSign] = 1'b1;
      if (is_num(c) && in_set(")x", p)) flags[esc_pkg::FailNum] = 1'b1;
      if (is_num(p) && in_set("(xcstal", c)) flags[esc_pkg::FailNum] = 1'b1;
      if (c == "x" && in_set("x)0123456789", p)) flags[esc_pkg::FailNum] = 1'b1;
      if (p == "x" && in_set("(0123456789cstal", c)) flags[esc_pkg::FailNum] = 1'b1;
    end
    if (c == "(") begin
      if (open_count != 8'd255) open_count++;
    end else if (c == ")") begin
      if (open_count == 0) flags[esc_pkg::FailBrack] = 1'b1;
      else open_count--;
    end
    if (in_set("acgilnoqrst", c)) begin
      if (name_len < 5) name_buf[8*name_len +: 8] = c;
      if (name_len < 7) name_len++;
    end else if (name_len > 0) begin
      if (c != "(" || !name_known()) flags[esc_pkg::FailFunc] = 1'b1;
      name_buf = '0;
      name_len = '0;
    end
    if (c == ".") begin
      if (dot_run < 2) dot_run++;
      if (dot_run > 1) flags[esc_pkg::FailNum] = 1'b1;
    end else if (!is_num(c)) begin
      dot_run = '0;
    end
    if (char_len != 8'd255) char_len++;
    prev_ch = c;
    if (!last) return 1'b0;
    if (open_count != 0) flags[esc_pkg::FailBrack] = 1'b1;
    if (name_len > 0) flags[esc_pkg::FailFunc] = 1'b1;
    if (char_len >= limit) flags[esc_pkg::FailLen] = 1'b1;
    v.ok = flags == 0;
    v.mask = flags;
    forget_formula();
    return 1'b1;
  endfunction

  function automatic logic [7:0] stray_char();
    string al = ".0123456789()+~-*/^%acgilnoqrstx";
    if ($urandom_range(1) == 0) return 8'($urandom_range(255));
    return al[$urandom_range(al.len() - 1)];
  endfunction

  task automatic send_char(input logic [7:0] c, input bit last, input int pinned);
    verdict_t v;
    bit held;
    while (!calm && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    is_last_i   <= last;
    do begin
      @(negedge clk_i);
      held = in_stall_o;
      @(posedge clk_i);
    end while (held);
    sent++;
    if (judge_char(c, last, v)) begin
      if (pinned >= 0) begin
        v.mask = pinned[esc_pkg::MaskW-1:0];
        v.ok = pinned == 0;
      end
      verdict_q.push_back(v);
    end
  endtask

  task automatic send_formula();
    for (int i = 0; i < formula_q.size(); i++) send_char(formula_q[i], i == formula_q.size() - 1, -1);
  endtask

  // well-formed expression of roughly the given length
  task automatic build_formula(input int target);
    int depth;
    int r;
    int n;
    bit operand;
    string s;
    string signs = "+-*/^%";
    formula_q.delete();
    depth = 0;
    operand = 1'b1;
    forever begin
      if (operand) begin
        r = $urandom_range(99);
        if (r < 15 && depth < 4) begin
          formula_q.push_back("(");
          depth++;
        end else if (r < 30 && depth < 4) begin
          s = fn_name($urandom_range(8));
          for (int i = 0; i < s.len(); i++) formula_q.push_back(s[i]);
          formula_q.push_back("(");
          depth++;
        end else if (r < 36) begin
          formula_q.push_back("~");
        end else if (r < 50) begin
          formula_q.push_back("x");
          operand = 1'b0;
        end else begin
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) formula_q.push_back(8'("0" + $urandom_range(9)));
          if ($urandom_range(3) == 0) begin
            formula_q.push_back(".");
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++) formula_q.push_back(8'("0" + $urandom_range(9)));
          end
          operand = 1'b0;
        end
      end else if (formula_q.size() >= target) begin
        if (depth == 0) break;
        formula_q.push_back(")");
        depth--;
      end else if (depth > 0 && $urandom_range(99) < 25) begin
        formula_q.push_back(")");
        depth--;
      end else begin
        formula_q.push_back(signs[$urandom_range(5)]);
        operand = 1'b1;
      end
    end
  endtask

  task automatic write_limit(input logic [7:0] value);
    logic [esc_pkg::DataW-1:0] word;
    bit ready;
    word = $urandom;
    word[7:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LimitAddr;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      ready = pready;
      @(posedge clk_i);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit = value;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) out_stall_i <= !calm && ($urandom_range(99) < 22);

  always @(posedge clk_i) begin : verdict_check
    verdict_t v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result: is_valid %0b fail_mask %0h", is_valid_o, fail_mask_o);
        fails++;
      end else begin
        v = verdict_q.pop_front();
        if (is_valid_o !== v.ok) begin
          $error("is_valid expected %0b, got %0b", v.ok, is_valid_o);
          fails++;
        end
        if (fail_mask_o !== v.mask) begin
          $error("fail_mask expected %0h, got %0h", v.mask, fail_mask_o);
          fails++;
        end
      end
    end
  end

  initial begin : stimulus
    string s;
    logic [7:0] c;
    int ph;
    int lim;
    int target;
    int r;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    char_code_i = '0;
    is_last_i   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    limit       = esc_pkg::LimitReset;
    forget_formula();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < NumRows; k++) begin
      s = row_text[k];
      for (int i = 0; i < s.len(); i++) begin
        c = s[i];
        if (c == "#") c = 8'h00;
        else if (c == "$") c = 8'hff;
        send_char(c, i == s.len() - 1, row_mask[k]);
      end
    end

    ph = 0;
    while (ph < 6 || sent < 1400) begin
      wait_drained();
      lim = (ph < 6) ? phase_limit[ph] : $urandom_range(1, 255);
      write_limit(lim[7:0]);
      calm = ph == 4;
      if (ph == 0) begin
        build_formula($urandom_range(246, 252));
        send_formula();
        build_formula($urandom_range(256, 270));
        send_formula();
        // deep nesting past the depth counter range
        formula_q.delete();
        repeat (257) formula_q.push_back("(");
        formula_q.push_back("1");
        send_formula();
      end
      repeat (9) begin
        target = $urandom_range(1, 14);
        if (lim <= 40 && $urandom_range(4) == 0)
          target = (lim > 2) ? lim - 2 + $urandom_range(3) : $urandom_range(1, 3);
        r = $urandom_range(99);
        if (r < 85) begin
          build_formula(target);
          if (r >= 60) begin
            target = $urandom_range(formula_q.size() - 1);
            case ($urandom_range(3))
              0: formula_q[target] = stray_char();
              1: formula_q.insert(target, stray_char());
              2: if (formula_q.size() > 1) formula_q.delete(target);
              default: while (formula_q.size() > target + 1) void'(formula_q.pop_back());
            endcase
          end
        end else begin
          formula_q.delete();
          repeat ($urandom_range(1, 12)) formula_q.push_back(stray_char());
        end
        send_formula();
      end
      ph++;
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    for (int w = 0; w < 4000 && verdict_q.size() != 0; w++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      $error("%0d results never arrived", verdict_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ expression_syntax_checker.f @@
hw/rtl/esc_pkg.sv
hw/rtl/esc_cfg.sv
hw/rtl/esc_rules.sv
hw/rtl/expression_syntax_checker.sv
tb/sv/tb.sv
